FILE: rtl/core/ingc_pkg.sv
// Shared types and constants of the inode number goal chooser.
package ingc_pkg;

    localparam int NUM_GROUPS_DEF = 1024;

    localparam int INUM_W   = 48;
    localparam int POS_W    = 32;
    localparam int USED_W   = 25;
    localparam int INDEX_W  = 10;
    localparam int FACTOR_W = 15;
    localparam int PROD_W   = FACTOR_W + POS_W;
    localparam int IDEAL_W  = 32;

    localparam logic [FACTOR_W-1:0] FILE_SCALE = FACTOR_W'((1 << 13) / 24);
    localparam logic [FACTOR_W-1:0] DIR_SCALE  = FACTOR_W'((50 * (1 << 13)) / 24);
    localparam logic [INUM_W-1:0]   CLUSTER_SPAN = 48'd32;
    localparam logic [INUM_W:0]     MKDIR_RANGE  = 49'd10;
    localparam logic [INUM_W-1:0]   AGE1_USED    = 48'd32768;
    localparam logic [INUM_W-1:0]   AGE2_USED    = 48'd262144;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_BLOCK_BITS    = 3'd0;
    localparam cfg_index_t CFG_GROUP_BITS    = 3'd1;
    localparam cfg_index_t CFG_VOLUME_BLOCKS = 3'd2;
    localparam cfg_index_t CFG_FIRST_NORMAL  = 3'd3;
    localparam cfg_index_t CFG_ROOT_DIR      = 3'd4;

    localparam logic [4:0]  RST_BLOCK_BITS   = 5'd12;
    localparam logic [4:0]  RST_GROUP_BITS   = 5'd13;
    localparam logic [47:0] RST_VOLUME       = 48'd0;
    localparam logic [15:0] RST_FIRST_NORMAL = 16'd64;
    localparam logic [15:0] RST_ROOT_DIR     = 16'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GUESS,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic guess;
        logic eval;
        logic scan;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_dir;
        logic hit;
        logic more;
    } status_t;

endpackage

FILE: rtl/core/ingc_in_if.sv
// Input channel of the inode number goal chooser.
interface ingc_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [9:0]  group_index;
    logic [24:0] group_used;
    logic [47:0] parent_inum;
    logic [47:0] next_inum;
    logic [31:0] entry_position;
    logic        is_directory;
    logic [47:0] free_blocks;

    modport source (
        output valid, func, group_index, group_used, parent_inum, next_inum,
               entry_position, is_directory, free_blocks,
        input  ready
    );
    modport sink (
        input  valid, func, group_index, group_used, parent_inum, next_inum,
               entry_position, is_directory, free_blocks,
        output ready
    );
endinterface

FILE: rtl/core/ingc_out_if.sv
// Result channel of the inode number goal chooser.
interface ingc_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] goal_inum;

    modport source (
        output valid, goal_inum,
        input  ready
    );
    modport sink (
        input  valid, goal_inum,
        output ready
    );
endinterface

FILE: rtl/core/ingc_ctrl.sv
// Controller state machine of the inode number goal chooser.
module ingc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  ingc_pkg::status_t st,
    output ingc_pkg::cmd_t    cmd
);
    import ingc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_func)
                begin
                    state_next = ST_GUESS;
                end
            end
            ST_GUESS:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = st.is_dir ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (st.hit || !st.more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        push      = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_GUESS:
            begin
                cmd.guess = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DONE:
            begin
                push     = !out_valid_reg || out_ready;
                cmd.push = push;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/ingc_dpath.sv
// Datapath of the inode number goal chooser: registers, usage table, arithmetic.
module ingc_dpath #(
    parameter int NUM_GROUPS = ingc_pkg::NUM_GROUPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ingc_in_if.sink              item,
    input  logic                 cfg_wr_en,
    input  ingc_pkg::cfg_index_t cfg_index,
    input  logic [47:0]          cfg_data,
    input  ingc_pkg::cmd_t       cmd,
    output ingc_pkg::status_t    st,
    output logic [47:0]          goal_inum
);
    import ingc_pkg::*;

    localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam logic [AW-1:0]     LAST_ADDR = AW'(NUM_GROUPS - 1);
    localparam logic [16:0]       NG17 = 17'(NUM_GROUPS);
    localparam logic [INUM_W-1:0] NG48 = INUM_W'(NUM_GROUPS);

    logic [4:0]  block_bits_reg;
    logic [4:0]  group_bits_reg;
    logic [47:0] volume_blocks_reg;
    logic [15:0] first_normal_reg;
    logic [15:0] root_dir_reg;

    logic [AW-1:0] clr_addr_reg;

    logic [USED_W-1:0] mem [NUM_GROUPS];
    logic [USED_W-1:0] rd_data_reg;
    logic              rd_in_range_reg;

    logic [INUM_W-1:0]  base_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [INUM_W-1:0]  next_reg;
    logic               is_dir_reg;
    logic [IDEAL_W-1:0] ideal_reg;
    logic [INUM_W-1:0]  guess_reg;
    logic [INUM_W-1:0]  cur_reg;
    logic [INUM_W-1:0]  limit_reg;
    logic               first_reg;
    logic [INUM_W-1:0]  goal_reg;
    logic [INUM_W-1:0]  out_data_reg;

    logic [INUM_W-1:0]   parent_inc;
    logic [INUM_W-1:0]   base_next;
    logic [FACTOR_W-1:0] factor;
    logic [INUM_W-1:0]   used;
    logic [IDEAL_W-1:0]  gs;
    logic [IDEAL_W-1:0]  ideal_next;
    logic                below_root;
    logic [INUM_W-1:0]   span;
    logic [INUM_W-1:0]   group;
    logic [INUM_W-1:0]   top;
    logic [INUM_W:0]     limit_wide;
    logic [INUM_W-1:0]   limit_next;
    logic [USED_W-1:0]   usage;
    logic [INUM_W:0]     nxt;
    logic [INUM_W-1:0]   rd_addr;
    logic                set_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bits_reg    <= RST_BLOCK_BITS;
            group_bits_reg    <= RST_GROUP_BITS;
            volume_blocks_reg <= RST_VOLUME;
            first_normal_reg  <= RST_FIRST_NORMAL;
            root_dir_reg      <= RST_ROOT_DIR;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BLOCK_BITS:    block_bits_reg    <= cfg_data[4:0];
                CFG_GROUP_BITS:    group_bits_reg    <= cfg_data[4:0];
                CFG_VOLUME_BLOCKS: volume_blocks_reg <= cfg_data;
                CFG_FIRST_NORMAL:  first_normal_reg  <= cfg_data[15:0];
                CFG_ROOT_DIR:      root_dir_reg      <= cfg_data[15:0];
                default:           block_bits_reg    <= block_bits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr && clr_addr_reg != LAST_ADDR)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Base, scaled position and ideal count of a choose word.
    always_comb
    begin
        parent_inc = item.parent_inum + 48'd1;
        base_next  = (parent_inc < {32'd0, first_normal_reg}) ?
                     {32'd0, first_normal_reg} : parent_inc;
        factor     = item.is_directory ? DIR_SCALE : FILE_SCALE;
        used       = (item.free_blocks > volume_blocks_reg) ?
                     48'd0 : volume_blocks_reg - item.free_blocks;
        gs         = 32'd1 << group_bits_reg;
        below_root = (item.parent_inum != {32'd0, root_dir_reg});
        if (used >= AGE2_USED)
        begin
            ideal_next = gs;
        end
        else if (used >= AGE1_USED)
        begin
            ideal_next = below_root ? (gs >> 1) : (gs >> 4);
        end
        else
        begin
            ideal_next = below_root ? (gs >> 3) : 32'd0;
        end
    end

    always_comb
    begin
        span       = (next_reg >= guess_reg) ? next_reg - guess_reg : guess_reg - next_reg;
        group      = guess_reg >> group_bits_reg;
        top        = volume_blocks_reg >> group_bits_reg;
        limit_wide = {1'b0, group} + MKDIR_RANGE;
        limit_next = (limit_wide > {1'b0, top}) ? top : limit_wide[INUM_W-1:0];
        usage      = rd_in_range_reg ? rd_data_reg : '0;
        nxt        = {1'b0, cur_reg} + 49'd1;
        st.clear_last = (clr_addr_reg == LAST_ADDR);
        st.hit     = ({7'd0, usage} <= ideal_reg);
        st.more    = (nxt < {1'b0, limit_reg});
        st.is_dir  = is_dir_reg;
        rd_addr    = cmd.eval ? group : nxt[INUM_W-1:0];
        set_write  = cmd.load && !item.func && (17'(item.group_index) < NG17);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (set_write)
        begin
            mem[AW'(item.group_index)] <= item.group_used;
        end
        rd_data_reg     <= mem[AW'(rd_addr)];
        rd_in_range_reg <= (rd_addr < NG48);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg   <= base_next;
            prod_reg   <= PROD_W'(factor) * PROD_W'(item.entry_position);
            next_reg   <= item.next_inum;
            is_dir_reg <= item.is_directory;
            ideal_reg  <= ideal_next;
        end
        if (cmd.guess)
        begin
            guess_reg <= base_reg + INUM_W'(prod_reg >> block_bits_reg);
        end
        if (cmd.eval)
        begin
            cur_reg   <= group;
            limit_reg <= limit_next;
            first_reg <= 1'b1;
            goal_reg  <= (span > CLUSTER_SPAN) ? guess_reg : next_reg;
        end
        if (cmd.scan)
        begin
            if (st.hit)
            begin
                goal_reg <= first_reg ? guess_reg : (cur_reg << group_bits_reg);
            end
            else if (st.more)
            begin
                cur_reg   <= nxt[INUM_W-1:0];
                first_reg <= 1'b0;
            end
            else
            begin
                goal_reg <= guess_reg;
            end
        end
        if (cmd.push)
        begin
            out_data_reg <= goal_reg;
        end
    end

    assign goal_inum = out_data_reg;

endmodule

FILE: rtl/core/inode_number_goal_chooser_core.sv
// Top level of the inode number goal chooser: controller, datapath and channel hookup.
// After reset the block clears its group usage table, one entry a cycle, and
// accepts no word during that pass; configuration writes are taken at any time.
// A set word with an index inside the table is written as it is accepted, and set
// words may follow back to back. A choose word for a file passes through shift and
// add, compare and hand-off to the result register. A choose word for a directory
// also scans the usage table, which has one registered read port; the scan reads
// the guessed group and up to nine following groups one per cycle.
// The next word is accepted as soon as the result is in the output register, and
// a finished result waits there until it is taken.
module inode_number_goal_chooser_core #(
    parameter int NUM_GROUPS = ingc_pkg::NUM_GROUPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ingc_in_if.sink              item,
    ingc_out_if.source           result,
    input  logic                 cfg_wr_en,
    input  ingc_pkg::cfg_index_t cfg_index,
    input  logic [47:0]          cfg_data
);
    import ingc_pkg::*;

    cmd_t        cmd;
    status_t     st;
    logic        in_ready;
    logic        out_valid;
    logic [47:0] goal_inum;

    ingc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_func   (item.func),
        .in_ready  (in_ready),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .st        (st),
        .cmd       (cmd)
    );

    ingc_dpath #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .goal_inum (goal_inum)
    );

    assign item.ready       = in_ready;
    assign result.valid     = out_valid;
    assign result.goal_inum = goal_inum;

endmodule
